// ===== rtl/preemptive_priority_scheduler_assert.svh =====
// ----------------------------------------------------------------------------
// preemptive priority scheduler assertion macros
// concurrent checks on the scheduler's control logic, sampled on clock
// ----------------------------------------------------------------------------
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_ASSERT_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define PPS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PPS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/pps_pkg.sv =====
// ----------------------------------------------------------------------------
// pps_pkg
// shared types and constants of the preemptive priority scheduler
// ----------------------------------------------------------------------------
package pps_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int RSP_COUNT_W = 5;

   localparam logic ACT_ARRIVAL  = 1'b0;
   localparam logic ACT_COMPLETE = 1'b1;

   typedef struct packed {
      logic        action;
      logic [15:0] timestamp;
      logic [7:0]  task_id;
      logic [15:0] task_arrival;
      logic [15:0] task_burst;
      logic [7:0]  task_priority;
   } req_type;

   typedef struct packed {
      logic [7:0]             run_id;
      logic [7:0]             run_priority;
      logic [15:0]            run_arrival;
      logic [15:0]            run_start;
      logic [15:0]            run_end;
      logic [15:0]            run_remaining;
      logic [RSP_COUNT_W-1:0] ready_count;
      logic                   dropped;
   } rsp_type;

   typedef struct packed {
      logic [15:0] remaining;
      logic [15:0] burst;
      logic [15:0] arrival;
      logic [7:0]  prio;
      logic [7:0]  id;
   } entry_type;

   typedef struct packed {
      logic      push;
      logic      pop;
      entry_type entry;
   } queue_cmd_type;

   typedef struct packed {
      logic               busy;
      logic               done;
      entry_type          entry;
      logic [COUNT_W-1:0] count;
   } queue_stat_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_POP,
      ST_EMIT
   } top_state_type;

   typedef enum logic [1:0] {
      QS_IDLE,
      QS_SCAN,
      QS_SHIFT,
      QS_DONE
   } queue_state_type;

endpackage

// ===== rtl/pps_queue.sv =====
// ----------------------------------------------------------------------------
// pps_queue
// ready queue in a synchronous memory: append, minimum scan and compaction
// ----------------------------------------------------------------------------
module pps_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  pps_pkg::queue_cmd_type cmd,
   output pps_pkg::queue_stat_type stat
);
   import pps_pkg::*;

   entry_type          mem [QUEUE_DEPTH];
   entry_type          rd_data_ff;
   queue_state_type    state_ff, state_in;
   logic [COUNT_W-1:0] size_ff, size_in;
   logic [COUNT_W-1:0] issue_ff, issue_in;
   logic               rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0]   rd_pos_ff, rd_pos_in;
   logic [IDX_W-1:0]   best_idx_ff, best_idx_in;
   entry_type          best_ff, best_in;
   logic               rd_en;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   entry_type          wr_data;
   logic               issue_more;
   logic               scan_last;
   logic               take;

   assign issue_more = (issue_ff < size_ff);
   assign scan_last  = rd_valid_ff && (rd_pos_ff == IDX_W'(size_ff - 1'b1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         QS_IDLE: begin
            if (cmd.pop) begin
               state_in = QS_SCAN;
            end
         end
         QS_SCAN: begin
            if (scan_last) begin
               state_in = QS_SHIFT;
            end
         end
         QS_SHIFT: begin
            if (!issue_more && !rd_valid_ff) begin
               state_in = QS_DONE;
            end
         end
         QS_DONE: begin
            state_in = QS_IDLE;
         end
         default: begin
            state_in = QS_IDLE;
         end
      endcase
   end

   always_comb begin
      issue_in    = issue_ff;
      size_in     = size_ff;
      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      rd_en       = 1'b0;
      rd_valid_in = 1'b0;
      rd_pos_in   = IDX_W'(issue_ff);
      wr_en       = 1'b0;
      wr_addr     = IDX_W'(size_ff);
      wr_data     = cmd.entry;
      take        = 1'b0;
      case (state_ff)
         QS_IDLE: begin
            issue_in = '0;
            if (cmd.push) begin
               wr_en   = 1'b1;
               size_in = size_ff + 1'b1;
            end
         end
         QS_SCAN: begin
            if (issue_more) begin
               rd_en       = 1'b1;
               rd_valid_in = 1'b1;
               issue_in    = issue_ff + 1'b1;
            end
            take = rd_valid_ff &&
                   ((rd_pos_ff == '0) || (rd_data_ff.prio < best_ff.prio));
            if (take) begin
               best_in     = rd_data_ff;
               best_idx_in = rd_pos_ff;
            end
            if (scan_last) begin
               issue_in = COUNT_W'(best_idx_in) + 1'b1;
            end
         end
         QS_SHIFT: begin
            if (issue_more) begin
               rd_en       = 1'b1;
               rd_valid_in = 1'b1;
               issue_in    = issue_ff + 1'b1;
            end
            if (rd_valid_ff) begin
               wr_en   = 1'b1;
               wr_addr = rd_pos_ff - 1'b1;
               wr_data = rd_data_ff;
            end
            if (!issue_more && !rd_valid_ff) begin
               size_in = size_ff - 1'b1;
            end
         end
         QS_DONE: begin
            issue_in = '0;
         end
         default: begin
            issue_in = '0;
         end
      endcase
      stat.busy  = (state_ff != QS_IDLE);
      stat.done  = (state_ff == QS_DONE);
      stat.entry = best_ff;
      stat.count = size_ff;
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[IDX_W'(issue_ff)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= QS_IDLE;
         size_ff     <= '0;
         issue_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         size_ff     <= size_in;
         issue_ff    <= issue_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_pos_ff   <= rd_pos_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
   end

endmodule

// ===== rtl/preemptive_priority_scheduler.sv =====
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler
// running task register and memory-based ready queue with preemption
//
//   channel   direction  ports                           payload
//   req       in         req_valid, req_ready, req_word  pps_pkg::req_type
//   rsp       out        rsp_valid, rsp_ready, rsp_word  pps_pkg::rsp_type
//
// an arrival's result word is registered in the execute state; next word in idle
// a completion with queued tasks does one memory read a cycle for the minimum
//   scan, then one move a cycle to close the gap
// reset clears the running task and the queue count; no clearing pass
// a new word is taken while a result waits; work stalls until rsp frees
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pps_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pps_pkg::rsp_type rsp_word
);
   import pps_pkg::*;

   `include "preemptive_priority_scheduler_assert.svh"

   top_state_type  state_ff, state_in;
   req_type        item_ff;
   entry_type      cur_ff, cur_in;
   logic [15:0]    start_ff, start_in;
   rsp_type        rsp_ff, rsp_in;
   logic           rsp_valid_ff, rsp_valid_in;
   queue_cmd_type  q_cmd;
   queue_stat_type q_stat;
   logic           slot_free;
   logic           q_full;
   logic [15:0]    elapsed;
   logic [15:0]    charged;
   logic           load;
   logic           dropped;
   logic [COUNT_W-1:0] count_out;
   entry_type      new_task;

   pps_queue u_queue (
      .clock (clock),
      .reset (reset),
      .cmd   (q_cmd),
      .stat  (q_stat)
   );

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign q_full    = (q_stat.count == COUNT_W'(QUEUE_DEPTH));
   assign elapsed   = item_ff.timestamp - start_ff;
   assign charged   = (cur_ff.remaining > elapsed) ? (cur_ff.remaining - elapsed) : 16'd0;
   assign new_task  = '{remaining: item_ff.task_burst, burst: item_ff.task_burst,
                        arrival: item_ff.task_arrival, prio: item_ff.task_priority,
                        id: item_ff.task_id};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if ((item_ff.action == ACT_COMPLETE) && (q_stat.count != '0)) begin
               state_in = ST_POP;
            end else if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_POP: begin
            if (q_stat.done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready   = (state_ff == ST_IDLE);
      cur_in      = cur_ff;
      start_in    = start_ff;
      q_cmd       = '0;
      q_cmd.entry = new_task;
      load        = 1'b0;
      dropped     = 1'b0;
      count_out   = q_stat.count;
      case (state_ff)
         ST_EXEC: begin
            if (item_ff.action == ACT_ARRIVAL) begin
               if (slot_free) begin
                  load = 1'b1;
                  if (item_ff.task_id == '0) begin
                     cur_in = cur_ff;
                  end else if (cur_ff.id == '0) begin
                     cur_in   = new_task;
                     start_in = item_ff.timestamp;
                  end else if (q_full) begin
                     dropped = 1'b1;
                  end else if (item_ff.task_priority >= cur_ff.prio) begin
                     q_cmd.push = 1'b1;
                     count_out  = q_stat.count + 1'b1;
                  end else begin
                     q_cmd.push            = 1'b1;
                     q_cmd.entry           = cur_ff;
                     q_cmd.entry.remaining = charged;
                     count_out             = q_stat.count + 1'b1;
                     cur_in                = new_task;
                     start_in              = item_ff.timestamp;
                  end
               end
            end else if (q_stat.count != '0) begin
               q_cmd.pop = 1'b1;
            end else if (slot_free) begin
               load     = 1'b1;
               cur_in   = '0;
               start_in = '0;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               load     = 1'b1;
               cur_in   = q_stat.entry;
               start_in = item_ff.timestamp;
            end
         end
         default: begin
            load = 1'b0;
         end
      endcase
      rsp_in               = rsp_ff;
      if (load) begin
         rsp_in.run_id        = cur_in.id;
         rsp_in.run_priority  = cur_in.prio;
         rsp_in.run_arrival   = cur_in.arrival;
         rsp_in.run_start     = start_in;
         rsp_in.run_end       = start_in + cur_in.remaining;
         rsp_in.run_remaining = cur_in.remaining;
         rsp_in.ready_count   = RSP_COUNT_W'(count_out);
         rsp_in.dropped       = dropped;
      end
      rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_ff       <= '0;
         start_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_word;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   `PPS_ASSERT_NOW(a_count_bound, 1'b1, q_stat.count <= COUNT_W'(QUEUE_DEPTH),
      "ready queue count beyond depth")
   `PPS_ASSERT_NOW(a_queue_busy_pop, q_stat.busy, state_ff == ST_POP,
      "queue sequencer busy outside pop wait")
   `PPS_ASSERT_NOW(a_drop_full, load && dropped, q_full && (cur_ff.id != '0),
      "drop flagged without full queue")
   `PPS_ASSERT_NEXT(a_pop_nonempty, q_cmd.pop, q_stat.busy && (state_ff == ST_POP),
      "pop issued without sequencer start")

endmodule

// ===== sim/preemptive_priority_scheduler_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_tb
// self-checking bench for the preemptive priority scheduler: a short table of
// directed events, then random arrival and completion traffic in fill, drain
// and mixed phases, results checked against a table or a behavioral model of
// the running task and ready queue, with bursty input and stalling output
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_tb;
   import pps_pkg::*;

   localparam int RANDOM_ITEMS = 600;
   localparam int TAIL_CYCLES  = 60;

   typedef struct packed {
      logic [7:0]  id;
      logic [7:0]  prio;
      logic [15:0] arrival;
      logic [15:0] burst;
      logic [15:0] remaining;
   } task_rec;

   typedef struct {
      req_type word;
      bit      typed;
      rsp_type want;
   } stim_row;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_word  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_word;

   // scheduler model state
   task_rec     waiting [QUEUE_DEPTH];
   int unsigned waiting_count = 0;
   task_rec     current       = '0;
   logic [15:0] current_start = '0;

   rsp_type expected_rsp[$];
   stim_row directed_rows[$];
   int      fail_count    = 0;
   int      results_seen  = 0;
   int      n_arrivals    = 0;
   int      n_completions = 0;
   int      n_preempts    = 0;
   int      n_drops       = 0;
   int      n_idle        = 0;
   int      burst_left    = 0;
   logic [15:0] tick_now  = '0;

   preemptive_priority_scheduler dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic rsp_type schedule_event(input req_type ev);
      rsp_type     r;
      task_rec     fresh;
      logic [15:0] elapsed;
      int unsigned best;
      int unsigned i;
      r = '0;
      fresh.id        = ev.task_id;
      fresh.prio      = ev.task_priority;
      fresh.arrival   = ev.task_arrival;
      fresh.burst     = ev.task_burst;
      fresh.remaining = ev.task_burst;
      if (ev.action == ACT_ARRIVAL) begin
         if (ev.task_id != 8'd0) begin
            n_arrivals++;
            if (current.id == 8'd0) begin
               current = fresh;
               current_start = ev.timestamp;
            end else if (waiting_count >= QUEUE_DEPTH) begin
               r.dropped = 1'b1;
               n_drops++;
            end else if (ev.task_priority >= current.prio) begin
               waiting[waiting_count] = fresh;
               waiting_count++;
            end else begin
               // charge the preempted task for the time it ran
               elapsed = ev.timestamp - current_start;
               if (current.remaining > elapsed) begin
                  current.remaining = current.remaining - elapsed;
               end else begin
                  current.remaining = '0;
               end
               waiting[waiting_count] = current;
               waiting_count++;
               current = fresh;
               current_start = ev.timestamp;
               n_preempts++;
            end
         end
      end else begin
         n_completions++;
         if (waiting_count == 0) begin
            current = '0;
            current_start = '0;
         end else begin
            best = 0;
            for (i = 1; i < waiting_count; i++) begin
               if (waiting[i].prio < waiting[best].prio) begin
                  best = i;
               end
            end
            current = waiting[best];
            for (i = best; i + 1 < waiting_count; i++) begin
               waiting[i] = waiting[i + 1];
            end
            waiting_count--;
            current_start = ev.timestamp;
         end
      end
      if (current.id == 8'd0) begin
         n_idle++;
      end
      r.run_id        = current.id;
      r.run_priority  = current.prio;
      r.run_arrival   = current.arrival;
      r.run_start     = current_start;
      r.run_end       = (current.id != 8'd0) ? current_start + current.remaining : 16'd0;
      r.run_remaining = current.remaining;
      r.ready_count   = RSP_COUNT_W'(waiting_count);
      return r;
   endfunction

   function automatic req_type arrive(input logic [15:0] ts, input logic [7:0] id,
                                      input logic [15:0] arr, input logic [15:0] burst,
                                      input logic [7:0] prio);
      req_type w;
      w.action        = ACT_ARRIVAL;
      w.timestamp     = ts;
      w.task_id       = id;
      w.task_arrival  = arr;
      w.task_burst    = burst;
      w.task_priority = prio;
      return w;
   endfunction

   function automatic req_type complete(input logic [15:0] ts);
      req_type w;
      w = '0;
      w.action    = ACT_COMPLETE;
      w.timestamp = ts;
      return w;
   endfunction

   function automatic rsp_type result_of(input logic [7:0] id, input logic [7:0] prio,
                                         input logic [15:0] arr, input logic [15:0] start,
                                         input logic [15:0] fin, input logic [15:0] rem);
      rsp_type r;
      r = '0;
      r.run_id        = id;
      r.run_priority  = prio;
      r.run_arrival   = arr;
      r.run_start     = start;
      r.run_end       = fin;
      r.run_remaining = rem;
      return r;
   endfunction

   function automatic req_type random_event(input int arrive_pct);
      req_type w;
      w.action        = 1'($urandom_range(1));
      w.timestamp     = 16'($urandom);
      w.task_id       = 8'($urandom);
      w.task_arrival  = 16'($urandom);
      w.task_burst    = 16'($urandom);
      w.task_priority = 8'($urandom);
      // noise: every field at full range
      if ($urandom_range(99) < 8) begin
         return w;
      end
      if ($urandom_range(99) < 2) begin
         tick_now = tick_now + 16'($urandom);
      end else begin
         tick_now = tick_now + 16'($urandom_range(40));
      end
      w.timestamp = tick_now;
      if ($urandom_range(99) < arrive_pct) begin
         w.action       = ACT_ARRIVAL;
         w.task_id      = 8'($urandom_range(255, 1));
         w.task_arrival = tick_now;
         if ($urandom_range(3) != 0) begin
            w.task_burst = 16'($urandom_range(200, 1));
         end
         if ($urandom_range(3) != 0) begin
            w.task_priority = 8'($urandom_range(7));
         end
      end else begin
         w.action = ACT_COMPLETE;
      end
      return w;
   endfunction

   task automatic send_word(input req_type w, input bit typed, input rsp_type want);
      rsp_type predicted;
      int      gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(3) == 0 ? $urandom_range(40, 10) : $urandom_range(8, 1);
         gap = $urandom_range(12, 1);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = schedule_event(w);
      expected_rsp.push_back(typed ? want : predicted);
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (expected_rsp.size() == 0) begin
         $error("result word with nothing expected: %h", got);
         fail_count++;
         return;
      end
      want = expected_rsp.pop_front();
      results_seen++;
      if (got.run_id !== want.run_id) begin
         $error("run_id expected %0h actual %0h", want.run_id, got.run_id);
         fail_count++;
      end
      if (got.run_priority !== want.run_priority) begin
         $error("run_priority expected %0h actual %0h", want.run_priority, got.run_priority);
         fail_count++;
      end
      if (got.run_arrival !== want.run_arrival) begin
         $error("run_arrival expected %0h actual %0h", want.run_arrival, got.run_arrival);
         fail_count++;
      end
      if (got.run_start !== want.run_start) begin
         $error("run_start expected %0h actual %0h", want.run_start, got.run_start);
         fail_count++;
      end
      if (got.run_end !== want.run_end) begin
         $error("run_end expected %0h actual %0h", want.run_end, got.run_end);
         fail_count++;
      end
      if (got.run_remaining !== want.run_remaining) begin
         $error("run_remaining expected %0h actual %0h", want.run_remaining,
                got.run_remaining);
         fail_count++;
      end
      if (got.ready_count !== want.ready_count) begin
         $error("ready_count expected %0d actual %0d", want.ready_count, got.ready_count);
         fail_count++;
      end
      if (got.dropped !== want.dropped) begin
         $error("dropped expected %0b actual %0b", want.dropped, got.dropped);
         fail_count++;
      end
   endtask

   // receiver: stall pattern changes every stretch, one long hold-off
   initial begin : drain_side
      int          hold_left;
      bit          hold_done;
      int          mode;
      int          mode_left;
      logic [7:0]  pattern;
      hold_left = 0;
      hold_done = 1'b0;
      mode      = 0;
      mode_left = 0;
      pattern   = 8'hff;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            check_result(rsp_word);
         end
         if (!hold_done && results_seen >= 150) begin
            hold_done = 1'b1;
            hold_left = 400;
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(3);
            mode_left = $urandom_range(80, 20);
            pattern   = 8'($urandom_range(255, 1));
         end
         mode_left--;
         pattern = {pattern[6:0], pattern[7]};
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(1));
               2: rsp_ready <= pattern[0];
               default: rsp_ready <= ($urandom_range(9) < 8);
            endcase
         end
      end
   end

   initial begin : timeout_guard
      #5_000_000;
      $display("timeout waiting on the scheduler");
      $display("preemptive_priority_scheduler verification failed");
      $finish;
   end

   initial begin : source_side
      req_type w;
      int      live_items;
      int      arrive_pct;
      int      drain_wait;
      bit      paused;
      // reset state and empty-queue idle
      directed_rows.push_back('{complete(16'h1234), 1'b1, '0});
      directed_rows.push_back('{arrive(16'h0005, 8'h00, 16'h0005, 16'h0009, 8'h03), 1'b1, '0});
      directed_rows.push_back('{arrive(16'hfff0, 8'hff, 16'hffff, 16'hffff, 8'h80), 1'b1,
                                result_of(8'hff, 8'h80, 16'hffff, 16'hfff0, 16'hffef,
                                          16'hffff)});
      directed_rows.push_back('{arrive(16'hfff8, 8'h01, 16'hfff8, 16'h0000, 8'h80), 1'b0, '0});
      directed_rows.push_back('{arrive(16'hfffc, 8'h02, 16'hfffc, 16'hffff, 8'hff), 1'b0, '0});
      // preempt across timestamp wrap
      directed_rows.push_back('{arrive(16'h0010, 8'h03, 16'h0010, 16'h0010, 8'h7f), 1'b0, '0});
      directed_rows.push_back('{arrive(16'h0011, 8'h00, 16'h0011, 16'h0040, 8'h00), 1'b0, '0});
      // preempt with charge past remaining time
      directed_rows.push_back('{arrive(16'h9000, 8'h04, 16'h9000, 16'h0001, 8'h00), 1'b0, '0});
      directed_rows.push_back('{arrive(16'h9001, 8'h05, 16'h9001, 16'h0000, 8'h00), 1'b0, '0});
      directed_rows.push_back('{arrive(16'h9002, 8'h06, 16'h9002, 16'h0020, 8'h80), 1'b0, '0});
      // drain with priority ties
      directed_rows.push_back('{complete(16'h9010), 1'b0, '0});
      directed_rows.push_back('{complete(16'h9020), 1'b0, '0});
      directed_rows.push_back('{complete(16'h9030), 1'b0, '0});
      directed_rows.push_back('{complete(16'h9040), 1'b0, '0});
      directed_rows.push_back('{complete(16'h9050), 1'b0, '0});
      directed_rows.push_back('{complete(16'h9060), 1'b0, '0});
      directed_rows.push_back('{complete(16'h9070), 1'b1, '0});
      directed_rows.push_back('{complete(16'hffff), 1'b1, '0});
      directed_rows.push_back('{arrive(16'h0000, 8'h80, 16'h0000, 16'h0000, 8'hff), 1'b1,
                                result_of(8'h80, 8'hff, 16'h0000, 16'h0000, 16'h0000,
                                          16'h0000)});
      directed_rows.push_back('{arrive(16'hffff, 8'h01, 16'hffff, 16'hffff, 8'h00), 1'b0, '0});
      directed_rows.push_back('{complete(16'h0000), 1'b0, '0});
      directed_rows.push_back('{complete(16'h0001), 1'b1, '0});

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);
      end

      live_items = 0;
      paused     = 1'b0;
      arrive_pct = 55;
      while (live_items < RANDOM_ITEMS) begin
         if (live_items % 60 == 0) begin
            case ((live_items / 60) % 3)
               0: arrive_pct = 85;
               1: arrive_pct = 30;
               default: arrive_pct = 55;
            endcase
         end
         if (!paused && live_items >= 300) begin
            // let everything in flight come out before going on
            paused = 1'b1;
            burst_left = 0;
            req_valid <= 1'b0;
            @(posedge clock);
            while (expected_rsp.size() != 0) @(posedge clock);
         end
         w = random_event(arrive_pct);
         send_word(w, 1'b0, '0);
         if (!(w.action == ACT_ARRIVAL && w.task_id == 8'd0)) begin
            live_items++;
         end
      end

      req_valid <= 1'b0;
      drain_wait = 0;
      while (expected_rsp.size() != 0 && drain_wait < 20000) begin
         @(posedge clock);
         drain_wait++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_rsp.size() != 0) begin
         $error("%0d expected result words never arrived", expected_rsp.size());
         fail_count++;
      end

      $display("checked %0d result words: %0d arrivals, %0d completions", results_seen,
               n_arrivals, n_completions);
      $display("seen %0d preemptions, %0d full-queue drops, %0d idle results", n_preempts,
               n_drops, n_idle);
      if (fail_count == 0) begin
         $display("preemptive_priority_scheduler verification clean");
      end else begin
         $display("preemptive_priority_scheduler verification failed");
      end
      $finish;
   end

endmodule
